>>> hdl/bmp_pkg.sv
// Shared types and constants for the binomial-mod-prime block.
// Used by the modular multiplier and the top level; depends on nothing.
package bmp_pkg;

  // Residue width and the fixed prime modulus.
  localparam int unsigned MOD_W = 20;
  localparam logic [MOD_W-1:0] PRIME = 20'd1000003;

  // Barrett reduction: quotient estimate and remainder widths.
  localparam int unsigned Q_W = MOD_W + 1;
  localparam int unsigned R_W = MOD_W + 2;
  localparam logic [63:0] BARRETT_WIDE = (64'd1 << (2 * MOD_W)) / 64'(PRIME);
  localparam logic [Q_W-1:0] BARRETT_M = BARRETT_WIDE[Q_W-1:0];

  // Fermat exponent for the inverse.
  localparam int unsigned EXP_W = MOD_W;
  localparam logic [EXP_W-1:0] INV_EXP = PRIME - 20'd2;

  // Result kind chosen at the entry of the pipeline.
  typedef enum logic [1:0] {
    KIND_ZERO = 2'd0,
    KIND_ONE  = 2'd1,
    KIND_CALC = 2'd2
  } kind_t;

  // Factorial table fill sequencer.
  typedef enum logic [1:0] {
    FILL_ISSUE = 2'd0,
    FILL_WAIT  = 2'd1,
    FILL_DONE  = 2'd2
  } fill_state_t;

endpackage

>>> hdl/binomial_mod_prime.sv
// Top level: n choose r modulo 1000003 over a pipelined Fermat inverse.
// Depends on bmp_pkg, bmp_ram and bmp_modmul.
//
//  channel | ports                          | contents
//  --------+--------------------------------+-------------------------------------
//  input   | in_tvalid in_tready in_tdata   | [15:0] n_total, [31:16] r_chosen
//  output  | out_tvalid out_tready out_tdata| [19:0] combinations, [23:20] zero
//
// One request enters per cycle while in_tready is high. The pipeline is 22
// chained five-stage modular multipliers (one product of two factorials, twenty
// square-and-multiply steps, one final product) plus the table read and the
// output register. After reset the factorial table is filled one entry at a
// time through a dedicated multiplier, each awaiting the last product, with
// in_tready low. A stalled output register holds its result while the
// pipeline keeps moving until its last stage is occupied.
module binomial_mod_prime #(
  parameter int unsigned TABLE_SIZE = 65536
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [15:0] n_total, [31:16] r_chosen
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata   // [19:0] combinations, [23:20] zero
);

  localparam int unsigned W = bmp_pkg::MOD_W;
  localparam int unsigned EW = bmp_pkg::EXP_W;
  localparam int unsigned DEPTH = (TABLE_SIZE < 65536) ? TABLE_SIZE : 65536;
  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned SW = W + 2;

  // ---------------- table fill ----------------
  bmp_pkg::fill_state_t fill_state_r, fill_state_nxt;
  logic [AW-1:0] fill_k_r;
  logic [W-1:0]  fill_prev_r;
  logic          fill_issue, fill_wr, fill_v;
  logic [W-1:0]  fill_prod, fill_op;
  logic          fill_last;
  logic          fill_side;

  assign fill_last = (fill_k_r == AW'(DEPTH - 1));
  assign fill_op   = (fill_k_r == '0) ? W'(1) : W'(fill_k_r);

  // Next fill state
  always_comb begin
    fill_state_nxt = fill_state_r;
    unique case (fill_state_r)
      bmp_pkg::FILL_ISSUE: fill_state_nxt = bmp_pkg::FILL_WAIT;
      bmp_pkg::FILL_WAIT: begin
        if (fill_v) begin
          fill_state_nxt = fill_last ? bmp_pkg::FILL_DONE : bmp_pkg::FILL_ISSUE;
        end
      end
      bmp_pkg::FILL_DONE: fill_state_nxt = bmp_pkg::FILL_DONE;
      default:            fill_state_nxt = bmp_pkg::FILL_ISSUE;
    endcase
  end

  // Fill outputs
  always_comb begin
    fill_issue = 1'b0;
    fill_wr    = 1'b0;
    unique case (fill_state_r)
      bmp_pkg::FILL_ISSUE: fill_issue = 1'b1;
      bmp_pkg::FILL_WAIT:  fill_wr    = fill_v;
      bmp_pkg::FILL_DONE:  fill_issue = 1'b0;
      default:             fill_issue = 1'b0;
    endcase
  end

  // Hold the running factorial and index
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_state_r <= bmp_pkg::FILL_ISSUE;
      fill_k_r     <= '0;
      fill_prev_r  <= W'(1);
    end else begin
      fill_state_r <= fill_state_nxt;
      if (fill_wr) begin
        fill_prev_r <= fill_prod;
        if (!fill_last) begin
          fill_k_r <= fill_k_r + AW'(1);
        end
      end
    end
  end

  bmp_modmul #(.SIDE_W(1)) u_fill_mul (
    .clk(clk), .rst_n(rst_n), .en(1'b1),
    .valid_i(fill_issue), .a_i(fill_prev_r), .b_i(fill_op), .side_i(1'b0),
    .valid_o(fill_v), .prod_o(fill_prod), .side_o(fill_side)
  );

  // ---------------- entry and table read ----------------
  logic          adv, tail_v;
  logic [15:0]   n_in, r_in, nr_in;
  bmp_pkg::kind_t kind_in, kind1_r;
  logic          v1_r;
  logic [W-1:0]  fn1, fr1, fnr1, unused_b;
  logic          fill_busy;

  assign fill_busy = (fill_state_r != bmp_pkg::FILL_DONE) || fill_side;
  assign in_tready = adv && !fill_busy;
  assign n_in  = in_tdata[15:0];
  assign r_in  = in_tdata[31:16];
  assign nr_in = n_in - r_in;

  // Classify the request
  always_comb begin
    if (r_in > n_in) begin
      kind_in = bmp_pkg::KIND_ZERO;
    end else if (r_in == 16'd0 || r_in == n_in) begin
      kind_in = bmp_pkg::KIND_ONE;
    end else if (17'(n_in) >= 17'(DEPTH)) begin
      kind_in = bmp_pkg::KIND_ZERO;
    end else begin
      kind_in = bmp_pkg::KIND_CALC;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_tvalid && in_tready;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      kind1_r <= kind_in;
    end
  end

  bmp_ram #(.WIDTH(W), .DEPTH(DEPTH)) u_ram_a (
    .clk(clk), .wr_en(fill_wr), .wr_addr(fill_k_r), .wr_data(fill_prod),
    .rd_en(adv), .rd_addr_a(n_in[AW-1:0]), .rd_addr_b(r_in[AW-1:0]),
    .rd_data_a(fn1), .rd_data_b(fr1)
  );

  bmp_ram #(.WIDTH(W), .DEPTH(DEPTH)) u_ram_b (
    .clk(clk), .wr_en(fill_wr), .wr_addr(fill_k_r), .wr_data(fill_prod),
    .rd_en(adv), .rd_addr_a(nr_in[AW-1:0]), .rd_addr_b(nr_in[AW-1:0]),
    .rd_data_a(fnr1), .rd_data_b(unused_b)
  );

  // ---------------- denominator product ----------------
  logic          den_v;
  logic [W-1:0]  den;
  logic [SW-1:0] den_side;

  bmp_modmul #(.SIDE_W(SW)) u_den_mul (
    .clk(clk), .rst_n(rst_n), .en(adv),
    .valid_i(v1_r), .a_i(fr1), .b_i(fnr1), .side_i({kind1_r, fn1}),
    .valid_o(den_v), .prod_o(den), .side_o(den_side)
  );

  // ---------------- inverse by square-and-multiply ----------------
  logic          acc_v    [0:EW];
  logic [W-1:0]  acc_w    [0:EW];
  logic [SW-1:0] acc_side [0:EW];
  logic [W-1:0]  base_w   [0:EW-1];

  assign acc_v[0]    = den_v;
  assign acc_w[0]    = W'(1);
  assign acc_side[0] = den_side;
  assign base_w[0]   = den;

  for (genvar i = 0; i < EW; i++) begin : g_pow
    logic [W-1:0] mul_op;
    assign mul_op = bmp_pkg::INV_EXP[i] ? base_w[i] : W'(1);

    bmp_modmul #(.SIDE_W(SW)) u_acc_mul (
      .clk(clk), .rst_n(rst_n), .en(adv),
      .valid_i(acc_v[i]), .a_i(acc_w[i]), .b_i(mul_op), .side_i(acc_side[i]),
      .valid_o(acc_v[i+1]), .prod_o(acc_w[i+1]), .side_o(acc_side[i+1])
    );

    if (i < EW - 1) begin : g_sq
      bmp_modmul #(.SIDE_W(1)) u_sq_mul (
        .clk(clk), .rst_n(rst_n), .en(adv),
        .valid_i(1'b0), .a_i(base_w[i]), .b_i(base_w[i]), .side_i(1'b0),
        .valid_o(), .prod_o(base_w[i+1]), .side_o()
      );
    end
  end

  // ---------------- final product and output ----------------
  logic          fin_v;
  logic [W-1:0]  fin;
  logic [1:0]    fin_kind;
  logic          out_valid_r;
  logic [W-1:0]  out_data_r;
  logic [W-1:0]  res_sel;

  bmp_modmul #(.SIDE_W(2)) u_fin_mul (
    .clk(clk), .rst_n(rst_n), .en(adv),
    .valid_i(acc_v[EW]), .a_i(acc_side[EW][W-1:0]), .b_i(acc_w[EW]),
    .side_i(acc_side[EW][SW-1:W]),
    .valid_o(fin_v), .prod_o(fin), .side_o(fin_kind)
  );

  assign tail_v = fin_v;
  // Advance unless the last stage would overwrite a waiting result
  assign adv = !(tail_v && out_valid_r && !out_tready);

  always_comb begin
    case (bmp_pkg::kind_t'(fin_kind))
      bmp_pkg::KIND_ONE:  res_sel = W'(1);
      bmp_pkg::KIND_CALC: res_sel = fin;
      default:            res_sel = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (tail_v && adv) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tail_v && adv) begin
      out_data_r <= res_sel;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'd0, out_data_r};

endmodule

>>> hdl/bmp_ram.sv
// Generic single-write, dual-read RAM with registered read data.
// Stand-alone; no package dependency.
module bmp_ram #(
  parameter int unsigned WIDTH = 20,
  parameter int unsigned DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
  output logic [WIDTH-1:0]         rd_data_a,
  output logic [WIDTH-1:0]         rd_data_b
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read ports, held while stalled
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
    end
  end

endmodule

>>> hdl/bmp_modmul.sv
// Five-stage pipelined multiplier modulo the prime, Barrett reduction.
// Depends on bmp_pkg for the modulus and reduction constants.
module bmp_modmul #(
  parameter int unsigned SIDE_W = 1
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic                      valid_i,
  input  logic [bmp_pkg::MOD_W-1:0] a_i,
  input  logic [bmp_pkg::MOD_W-1:0] b_i,
  input  logic [SIDE_W-1:0]         side_i,
  output logic                      valid_o,
  output logic [bmp_pkg::MOD_W-1:0] prod_o,
  output logic [SIDE_W-1:0]         side_o
);

  localparam int unsigned W = bmp_pkg::MOD_W;
  localparam int unsigned QW = bmp_pkg::Q_W;
  localparam int unsigned RW = bmp_pkg::R_W;
  localparam logic [RW-1:0] P1 = RW'(bmp_pkg::PRIME);
  localparam logic [RW-1:0] P2 = RW'(bmp_pkg::PRIME) << 1;

  logic [4:0]        v_r;
  logic [SIDE_W-1:0] side_r [0:4];
  logic [2*W-1:0]    x1_r;
  logic [2*QW-1:0]   t2_r;
  logic [RW-1:0]     x2_r, x3_r, qp3_r, r4_r;
  logic [W-1:0]      res5_r;
  logic [QW-1:0]     q3;
  logic [QW+W-1:0]   qp_full;
  logic [W-1:0]      res_nxt;

  // Valid bits advance with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[3:0], valid_i};
    end
  end

  assign q3      = t2_r[2*QW-1:QW];
  assign qp_full = q3 * bmp_pkg::PRIME;

  // Fold the Barrett remainder, known below three times the prime
  always_comb begin
    if (r4_r >= P2) begin
      res_nxt = W'(r4_r - P2);
    end else if (r4_r >= P1) begin
      res_nxt = W'(r4_r - P1);
    end else begin
      res_nxt = W'(r4_r);
    end
  end

  // Datapath stages: product, quotient estimate, q*p, subtract, fold
  always_ff @(posedge clk) begin
    if (en) begin
      x1_r      <= a_i * b_i;
      side_r[0] <= side_i;
      t2_r      <= x1_r[2*W-1:W-1] * bmp_pkg::BARRETT_M;
      x2_r      <= x1_r[RW-1:0];
      side_r[1] <= side_r[0];
      qp3_r     <= qp_full[RW-1:0];
      x3_r      <= x2_r;
      side_r[2] <= side_r[1];
      r4_r      <= x3_r - qp3_r;
      side_r[3] <= side_r[2];
      res5_r    <= res_nxt;
      side_r[4] <= side_r[3];
    end
  end

  assign valid_o = v_r[4];
  assign prod_o  = res5_r;
  assign side_o  = side_r[4];

endmodule

>>> verif/binomial_mod_prime_tb.sv
// Self-checking testbench for binomial_mod_prime: n choose r modulo 1000003.
// Depends on the binomial_mod_prime RTL with bmp_pkg, bmp_ram and bmp_modmul.
`timescale 1ns / 1ps

module binomial_mod_prime_tb;

  localparam int unsigned TABLE_SIZE = 65536;
  localparam longint unsigned P = 1000003;
  localparam int unsigned RANDOM_ITEMS = 1340;
  localparam longint unsigned CYCLE_LIMIT = 2000000;
  localparam int unsigned DRAIN_CYCLES = 300;
  localparam int unsigned LONG_HOLD = 600;
  localparam int NO_VALUE = -1;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;   // [15:0] n_total, [31:16] r_chosen
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;  // [19:0] combinations, [23:20] zero

  typedef struct {
    logic [15:0] n_total;
    logic [15:0] r_chosen;
    int          known;   // typed-in answer, or NO_VALUE
  } query_row_t;

  longint unsigned fact_mod [TABLE_SIZE];
  logic [19:0]     pending_combos [$];
  int unsigned     requests_sent;
  int unsigned     fail_count;
  longint unsigned cycle_count;
  bit              hold_out;
  query_row_t      directed_rows [$];

  binomial_mod_prime #(.TABLE_SIZE(TABLE_SIZE)) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always #1 clk = ~clk;

  // Modular power by square-and-multiply.
  function automatic longint unsigned pow_mod(longint unsigned base, longint unsigned ex);
    longint unsigned acc;
    longint unsigned b;
    acc = 1;
    b = base % P;
    while (ex != 0) begin
      if (ex[0]) acc = (acc * b) % P;
      b = (b * b) % P;
      ex = ex >> 1;
    end
    return acc;
  endfunction

  // Predict n choose r mod P via Fermat inverses of the factorials.
  function automatic logic [19:0] choose_mod(logic [15:0] n, logic [15:0] r);
    longint unsigned acc;
    if (r > n) return 20'd0;
    if (r == 0 || r == n) return 20'd1;
    if (n >= TABLE_SIZE) return 20'd0;
    acc = (fact_mod[n] * pow_mod(fact_mod[r], P - 2)) % P;
    acc = (acc * pow_mod(fact_mod[n - r], P - 2)) % P;
    return acc[19:0];
  endfunction

  // Offer one request, hold it until accepted, then queue its answer.
  task automatic send_query(logic [15:0] n, logic [15:0] r, int known);
    in_tvalid <= 1'b1;
    in_tdata  <= {r, n};
    do @(posedge clk); while (!in_tready);
    requests_sent++;
    if (known != NO_VALUE) pending_combos.push_back(known[19:0]);
    else pending_combos.push_back(choose_mod(n, r));
  endtask

  // Insert a random gap after a request, ending bursts now and then.
  task automatic sender_gap(ref int unsigned burst_left);
    int unsigned gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 40);
      gap = $urandom_range(1, 12);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Receiver: stall pattern that picks a new random mode each time its phase counter wraps.
  initial begin
    int unsigned mode;
    int unsigned phase;
    out_tready = 1'b0;
    mode = 0;
    phase = 0;
    forever begin
      @(posedge clk);
      if (phase == 0) mode = $urandom_range(0, 3);
      phase = (phase + 1) % 64;
      if (hold_out) out_tready <= 1'b0;
      else case (mode)
        0: out_tready <= 1'b1;
        1: out_tready <= ($urandom_range(0, 3) != 0);
        2: out_tready <= ($urandom_range(0, 3) == 0);
        default: out_tready <= 1'($urandom_range(0, 1));
      endcase
    end
  end

  // Long receiver hold-off once the pipeline is busy.
  initial begin
    hold_out = 1'b0;
    wait (requests_sent >= 300);
    hold_out = 1'b1;
    repeat (LONG_HOLD) @(posedge clk);
    hold_out = 1'b0;
  end

  // Check each delivered result against the oldest pending answer.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_combos.size() == 0) begin
        $error("unexpected result: combinations actual %0d", out_tdata[19:0]);
        fail_count++;
      end else begin
        if (out_tdata[19:0] !== pending_combos[0]) begin
          $error("combinations mismatch: expected %0d actual %0d",
                 pending_combos[0], out_tdata[19:0]);
          fail_count++;
        end
        if (out_tdata[23:20] !== 4'd0) begin
          $error("pad mismatch: expected 0 actual %0d", out_tdata[23:20]);
          fail_count++;
        end
        void'(pending_combos.pop_front());
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Stimulus: directed rows, then random queries, then drain.
  initial begin
    int unsigned burst_left;
    int unsigned pick;
    logic [15:0] n;
    logic [15:0] r;
    clk = 1'b0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    requests_sent = 0;
    fail_count = 0;
    cycle_count = 0;
    burst_left = 0;

    fact_mod[0] = 1;
    for (int k = 1; k < TABLE_SIZE; k++) fact_mod[k] = (fact_mod[k - 1] * k) % P;

    // Extremes, r above n, r zero, r equal to n, small readable cases.
    directed_rows = '{
      '{16'd0,     16'd0,     1},
      '{16'd65535, 16'd65535, 1},
      '{16'd65535, 16'd0,     1},
      '{16'd0,     16'd65535, 0},
      '{16'd0,     16'd1,     0},
      '{16'd65534, 16'd65535, 0},
      '{16'd1,     16'd0,     1},
      '{16'd1,     16'd1,     1},
      '{16'd5,     16'd2,     10},
      '{16'd10,    16'd3,     120},
      '{16'd65535, 16'd1,     65535},
      '{16'd65535, 16'd65534, 65535},
      '{16'd65535, 16'd32767, NO_VALUE},
      '{16'd65535, 16'd32768, NO_VALUE},
      '{16'd40000, 16'd12345, NO_VALUE},
      '{16'd2,     16'd1,     2},
      '{16'd21845, 16'd10922, NO_VALUE},
      '{16'd43690, 16'd21845, NO_VALUE}
    };

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      send_query(directed_rows[i].n_total, directed_rows[i].r_chosen,
                 directed_rows[i].known);
      sender_gap(burst_left);
    end

    for (int unsigned i = 0; i < RANDOM_ITEMS; i++) begin
      // Pause once until every pending answer has arrived.
      if (i == 700) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
        wait (pending_combos.size() == 0);
        @(posedge clk);
      end
      pick = $urandom_range(0, 9);
      n = 16'($urandom());
      if (pick < 8) begin
        r = 16'($urandom_range(0, n));
      end else if (pick == 8) begin
        if (n == 16'hFFFF) n = 16'($urandom_range(0, 65534));
        r = 16'($urandom_range(n + 1, 65535));
      end else begin
        r = 16'($urandom());
      end
      send_query(n, r, NO_VALUE);
      sender_gap(burst_left);
    end
    in_tvalid <= 1'b0;

    wait (pending_combos.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule
